/* hdl/eprp_pkg.sv */
package eprp_pkg;

	localparam int ACTION_W = 2;
	localparam int WIN_X_W = 10;
	localparam int WIN_Y_W = 9;
	localparam int COUNT_W = 9;
	localparam int AREA_W = 22;
	localparam int SUM_W = 32;

	// decision codes
	localparam logic [ACTION_W-1:0] ACT_PARTIAL = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_FULL = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_REJECT = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_PARTIAL_CAP = 2'd0;
	localparam logic [1:0] REG_AREA_CAP = 2'd1;
	localparam logic [1:0] REG_ENERGY_LEVEL = 2'd2;

	localparam logic [7:0] RESET_PARTIAL_CAP = 8'd10;
	localparam logic [3:0] RESET_AREA_CAP = 4'd2;
	localparam logic [1:0] RESET_ENERGY_LEVEL = 2'd0;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic mode;
		logic signed [11:0] rect_x;
		logic signed [11:0] rect_y;
		logic signed [11:0] rect_width;
		logic signed [11:0] rect_height;
	} request_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [WIN_X_W-1:0] win_x;
		logic [WIN_Y_W-1:0] win_y;
		logic [WIN_X_W-1:0] win_width;
		logic [WIN_Y_W-1:0] win_height;
		logic [AREA_W-1:0] area;
	} plan_t;

endpackage

/* hdl/eprp_plan.sv */
module eprp_plan #(
	parameter int SCREEN_W = 480,
	parameter int SCREEN_H = 800
) (
	input eprp_pkg::request_t req,
	input logic [7:0] partial_cap,
	input logic [3:0] area_cap,
	input logic [1:0] energy_level,
	input logic [eprp_pkg::COUNT_W-1:0] partial_count,
	input logic [eprp_pkg::SUM_W-1:0] partial_area_sum,
	output eprp_pkg::plan_t plan
);

	localparam logic signed [13:0] UI_W_S = 14'(SCREEN_W);
	localparam logic signed [13:0] UI_H_S = 14'(SCREEN_H);
	localparam logic [31:0] SCREEN_AREA = 32'(SCREEN_W * SCREEN_H);
	localparam logic signed [13:0] BYTE_MASK = ~14'sd7;

	logic signed [13:0] x, y, w, h, xe, ye;
	logic signed [13:0] xc, yc, xec, yec;
	logic signed [13:0] dx, dy;
	logic signed [13:0] nx, ny, ne_r, ne, nw;
	logic empty;
	logic [8:0] lim;
	logic [4:0] scr;
	logic [31:0] alim, sum_next;
	logic [eprp_pkg::AREA_W-1:0] area;
	logic promote;

	always_comb begin
		x = 14'(req.rect_x);
		y = 14'(req.rect_y);
		w = 14'(req.rect_width);
		h = 14'(req.rect_height);
		xe = x + w;
		ye = y + h;
		xc = (x < 14'sd0) ? 14'sd0 : x;
		yc = (y < 14'sd0) ? 14'sd0 : y;
		xec = (xe > UI_W_S) ? UI_W_S : xe;
		yec = (ye > UI_H_S) ? UI_H_S : ye;
		empty = (w <= 14'sd0) || (h <= 14'sd0) || (xc >= xec) || (yc >= yec);
		dx = xec - xc;
		dy = yec - yc;
		area = dx[10:0] * dy[10:0];

		// energy level two and above doubles both limits
		lim = energy_level[1] ? {partial_cap, 1'b0} : {1'b0, partial_cap};
		scr = energy_level[1] ? {area_cap, 1'b0} : {1'b0, area_cap};
		alim = SCREEN_AREA * 32'(scr);
		sum_next = partial_area_sum + 32'(area);
		promote = (partial_cap != 8'd0) &&
			((partial_count >= lim) || (sum_next >= alim));

		// rotate to native, then round columns out to whole bytes
		nx = yc & BYTE_MASK;
		ny = UI_W_S - xec;
		ne_r = (yec + 14'sd7) & BYTE_MASK;
		ne = (ne_r > UI_H_S) ? UI_H_S : ne_r;
		nw = ne - nx;

		plan.area = area;
		if (req.mode && empty) begin
			plan.action = eprp_pkg::ACT_REJECT;
			plan.win_x = '0;
			plan.win_y = '0;
			plan.win_width = '0;
			plan.win_height = '0;
		end else if (!req.mode || promote) begin
			plan.action = eprp_pkg::ACT_FULL;
			plan.win_x = '0;
			plan.win_y = '0;
			plan.win_width = eprp_pkg::WIN_X_W'(SCREEN_H);
			plan.win_height = eprp_pkg::WIN_Y_W'(SCREEN_W);
		end else begin
			plan.action = eprp_pkg::ACT_PARTIAL;
			plan.win_x = nx[eprp_pkg::WIN_X_W-1:0];
			plan.win_y = ny[eprp_pkg::WIN_Y_W-1:0];
			plan.win_width = nw[eprp_pkg::WIN_X_W-1:0];
			plan.win_height = dx[eprp_pkg::WIN_Y_W-1:0];
		end
	end

endmodule

/* hdl/epaper_partial_refresh_planner_core.sv */
// E-paper refresh planner: takes one request word per cycle unless in_stall
// is high (full frame, or a portrait UI rectangle) and answers each with one
// decision word: partial refresh with a byte-aligned native window, full
// refresh, or rejected. A request is registered on entry, planned by one
// level of clip, area multiply and limit compare logic, and registered on
// exit, at one word per clock while out_stall is low; the partial count and
// area sum update as a result is registered and are seen by the very next
// request. The configuration registers take a write in any cycle (cfg_ready
// is always high) but should only be written while no request is in flight.
module epaper_partial_refresh_planner_core #(
	parameter int SCREEN_W = 480,
	parameter int SCREEN_H = 800
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic mode,
	input logic signed [11:0] rect_x,
	input logic signed [11:0] rect_y,
	input logic signed [11:0] rect_width,
	input logic signed [11:0] rect_height,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] action,
	output logic [9:0] win_x,
	output logic [8:0] win_y,
	output logic [9:0] win_width,
	output logic [8:0] win_height,
	output logic [8:0] partials_since_full,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [7:0] cfg_data
);

	logic [7:0] partial_cap_q;
	logic [3:0] area_cap_q;
	logic [1:0] energy_level_q;
	logic [eprp_pkg::COUNT_W-1:0] partial_count_q;
	logic [eprp_pkg::SUM_W-1:0] partial_area_sum_q;

	eprp_pkg::request_t req_s1;
	logic valid_s1;
	eprp_pkg::plan_t plan;
	logic advance;
	logic [eprp_pkg::COUNT_W-1:0] count_next;

	logic out_valid_q;
	logic [1:0] action_q;
	logic [9:0] win_x_q;
	logic [8:0] win_y_q;
	logic [9:0] win_width_q;
	logic [8:0] win_height_q;
	logic [8:0] partials_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_cap_q <= eprp_pkg::RESET_PARTIAL_CAP;
			area_cap_q <= eprp_pkg::RESET_AREA_CAP;
			energy_level_q <= eprp_pkg::RESET_ENERGY_LEVEL;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				eprp_pkg::REG_PARTIAL_CAP: partial_cap_q <= cfg_data;
				eprp_pkg::REG_AREA_CAP: area_cap_q <= cfg_data[3:0];
				eprp_pkg::REG_ENERGY_LEVEL: energy_level_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// stage one moves on when the result register is free or being drained
	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1.mode <= mode;
			req_s1.rect_x <= rect_x;
			req_s1.rect_y <= rect_y;
			req_s1.rect_width <= rect_width;
			req_s1.rect_height <= rect_height;
		end
	end

	eprp_plan #(
		.SCREEN_W(SCREEN_W),
		.SCREEN_H(SCREEN_H)
	) u_plan (
		.req(req_s1),
		.partial_cap(partial_cap_q),
		.area_cap(area_cap_q),
		.energy_level(energy_level_q),
		.partial_count(partial_count_q),
		.partial_area_sum(partial_area_sum_q),
		.plan(plan)
	);

	always_comb begin
		unique case (plan.action)
			eprp_pkg::ACT_FULL: count_next = '0;
			eprp_pkg::ACT_PARTIAL: count_next = (partial_count_q == eprp_pkg::COUNT_MAX) ?
				partial_count_q : partial_count_q + 1'b1;
			default: count_next = partial_count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_count_q <= '0;
			partial_area_sum_q <= '0;
		end else if (advance) begin
			partial_count_q <= count_next;
			if (plan.action == eprp_pkg::ACT_FULL) begin
				partial_area_sum_q <= '0;
			end else if (plan.action == eprp_pkg::ACT_PARTIAL) begin
				partial_area_sum_q <= partial_area_sum_q + 32'(plan.area);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q <= plan.action;
			win_x_q <= plan.win_x;
			win_y_q <= plan.win_y;
			win_width_q <= plan.win_width;
			win_height_q <= plan.win_height;
			partials_q <= count_next;
		end
	end

	assign out_valid = out_valid_q;
	assign action = action_q;
	assign win_x = win_x_q;
	assign win_y = win_y_q;
	assign win_width = win_width_q;
	assign win_height = win_height_q;
	assign partials_since_full = partials_q;

endmodule

/* dv/tb_epaper_partial_refresh_planner_core.sv */
`timescale 1ns / 1ps

module tb_epaper_partial_refresh_planner_core;

	localparam int UI_W = 480;
	localparam int UI_H = 800;

	typedef struct packed {
		logic [1:0] action;
		logic [9:0] win_x;
		logic [8:0] win_y;
		logic [9:0] win_width;
		logic [8:0] win_height;
		logic [8:0] partials;
	} decision_t;

	class refresh_decision_tracker;
		logic [7:0] partial_cap = eprp_pkg::RESET_PARTIAL_CAP;
		logic [3:0] area_cap = eprp_pkg::RESET_AREA_CAP;
		logic [1:0] energy_level = eprp_pkg::RESET_ENERGY_LEVEL;
		logic [8:0] partial_count = '0;
		logic [31:0] area_sum = '0;
		decision_t pending_decisions[$];
		int errors = 0;
		int n_partial = 0;
		int n_full = 0;
		int n_promoted = 0;
		int n_reject = 0;
		int peak_count = 0;

		function void write_reg(logic [1:0] idx, logic [7:0] data);
			case (idx)
				eprp_pkg::REG_PARTIAL_CAP: partial_cap = data;
				eprp_pkg::REG_AREA_CAP: area_cap = data[3:0];
				eprp_pkg::REG_ENERGY_LEVEL: energy_level = data[1:0];
				default: ;
			endcase
		endfunction

		function decision_t full_refresh();
			decision_t d;
			partial_count = '0;
			area_sum = '0;
			n_full++;
			d = '0;
			d.action = eprp_pkg::ACT_FULL;
			d.win_width = 10'(UI_H);
			d.win_height = 9'(UI_W);
			return d;
		endfunction

		function void take_request(eprp_pkg::request_t r);
			int x0, y0, x1, y1, nx, ne;
			logic [31:0] area, alim, scr;
			logic [9:0] lim;
			decision_t d;
			d = '0;
			if (!r.mode) begin
				pending_decisions.push_back(full_refresh());
				return;
			end
			x0 = $signed(r.rect_x);
			y0 = $signed(r.rect_y);
			x1 = x0 + $signed(r.rect_width);
			y1 = y0 + $signed(r.rect_height);
			if (x0 < 0) x0 = 0;
			if (y0 < 0) y0 = 0;
			if (x1 > UI_W) x1 = UI_W;
			if (y1 > UI_H) y1 = UI_H;
			if ($signed(r.rect_width) <= 0 || $signed(r.rect_height) <= 0 ||
					x0 >= x1 || y0 >= y1) begin
				d.action = eprp_pkg::ACT_REJECT;
				d.partials = partial_count;
				n_reject++;
				pending_decisions.push_back(d);
				return;
			end
			area = 32'(x1 - x0) * 32'(y1 - y0);
			if (partial_cap != 0) begin
				lim = {2'b00, partial_cap};
				scr = {28'd0, area_cap};
				// level 3 behaves as level 2
				if (energy_level >= 2) begin
					lim = lim << 1;
					scr = scr << 1;
				end
				alim = 32'(UI_W * UI_H) * scr;
				if ({1'b0, partial_count} >= lim || 32'(area_sum + area) >= alim) begin
					n_promoted++;
					pending_decisions.push_back(full_refresh());
					return;
				end
			end
			// rotate to native, then round the columns out to whole bytes
			nx = y0 & ~7;
			ne = (y1 + 7) & ~7;
			if (ne > UI_H) ne = UI_H;
			d.action = eprp_pkg::ACT_PARTIAL;
			d.win_x = 10'(nx);
			d.win_y = 9'(UI_W - x1);
			d.win_width = 10'(ne - nx);
			d.win_height = 9'(x1 - x0);
			if (partial_count != eprp_pkg::COUNT_MAX) partial_count++;
			area_sum += area;
			if (partial_count > peak_count) peak_count = partial_count;
			d.partials = partial_count;
			n_partial++;
			pending_decisions.push_back(d);
		endfunction

		function int field_bad(string name, logic [31:0] exp_v, logic [31:0] got_v);
			if (got_v !== exp_v) begin
				$error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
				return 1;
			end
			return 0;
		endfunction

		function void check_decision(decision_t got);
			decision_t exp_d;
			if (pending_decisions.size() == 0) begin
				$error("decision word with no request outstanding");
				errors++;
				return;
			end
			exp_d = pending_decisions.pop_front();
			errors += field_bad("action", exp_d.action, got.action);
			errors += field_bad("win_x", exp_d.win_x, got.win_x);
			errors += field_bad("win_y", exp_d.win_y, got.win_y);
			errors += field_bad("win_width", exp_d.win_width, got.win_width);
			errors += field_bad("win_height", exp_d.win_height, got.win_height);
			errors += field_bad("partials_since_full", exp_d.partials, got.partials);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic mode;
	logic signed [11:0] rect_x;
	logic signed [11:0] rect_y;
	logic signed [11:0] rect_width;
	logic signed [11:0] rect_height;
	logic out_valid;
	logic out_stall;
	logic [1:0] action;
	logic [9:0] win_x;
	logic [8:0] win_y;
	logic [9:0] win_width;
	logic [8:0] win_height;
	logic [8:0] partials_since_full;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	refresh_decision_tracker tracker;
	decision_t seen_word;
	int n_settings;

	epaper_partial_refresh_planner_core #(
		.SCREEN_W(UI_W),
		.SCREEN_H(UI_H)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.rect_x(rect_x),
		.rect_y(rect_y),
		.rect_width(rect_width),
		.rect_height(rect_height),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.action(action),
		.win_x(win_x),
		.win_y(win_y),
		.win_width(win_width),
		.win_height(win_height),
		.partials_since_full(partials_since_full),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver back-pressure, with a stall rate picked anew at random intervals
	initial begin
		int stall_pct;
		out_stall = 1'b0;
		forever begin
			case ($urandom_range(4))
				0, 1: stall_pct = 0;
				2: stall_pct = 25;
				3: stall_pct = 60;
				default: stall_pct = 90;
			endcase
			repeat ($urandom_range(20, 120)) begin
				@(negedge clk);
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_word.action = action;
			seen_word.win_x = win_x;
			seen_word.win_y = win_y;
			seen_word.win_width = win_width;
			seen_word.win_height = win_height;
			seen_word.partials = partials_since_full;
			tracker.check_decision(seen_word);
		end
	end

	task automatic send_item(logic m, int x, int y, int w, int h);
		eprp_pkg::request_t req;
		@(negedge clk);
		in_valid <= 1'b1;
		mode <= m;
		rect_x <= 12'(x);
		rect_y <= 12'(y);
		rect_width <= 12'(w);
		rect_height <= 12'(h);
		do @(posedge clk); while (in_stall);
		req.mode = m;
		req.rect_x = 12'(x);
		req.rect_y = 12'(y);
		req.rect_width = 12'(w);
		req.rect_height = 12'(h);
		tracker.take_request(req);
	endtask

	task automatic pause(int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// hold off until every outstanding word has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending_decisions.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, data);
	endtask

	task automatic configure(logic [7:0] lim, logic [3:0] scr, logic [1:0] lvl);
		drain();
		write_reg(eprp_pkg::REG_PARTIAL_CAP, lim);
		write_reg(eprp_pkg::REG_AREA_CAP, {4'($urandom), scr});
		write_reg(eprp_pkg::REG_ENERGY_LEVEL, {6'($urandom), lvl});
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic run_phase(logic [7:0] lim, logic [3:0] scr, logic [1:0] lvl, int items,
			int full_pct, int noise_pct, bit gappy);
		int x, y, w, h, k, pick, burst;
		configure(lim, scr, lvl);
		burst = $urandom_range(1, 16);
		repeat (items) begin
			pick = $urandom_range(99);
			if (pick < full_pct + noise_pct) begin
				x = int'($urandom_range(4095)) - 2048;
				y = int'($urandom_range(4095)) - 2048;
				w = int'($urandom_range(4095)) - 2048;
				h = int'($urandom_range(4095)) - 2048;
			end else begin
				x = $urandom_range(UI_W - 1);
				y = $urandom_range(UI_H - 1);
				if ($urandom_range(9) < 8) begin
					w = $urandom_range(1, 48);
					h = $urandom_range(1, 48);
				end else begin
					w = $urandom_range(1, 900);
					h = $urandom_range(1, 900);
				end
				// hang over the left or top edge now and then
				if ($urandom_range(5) == 0) begin
					k = $urandom_range(1, 40);
					x -= k;
					w += k;
				end
				if ($urandom_range(5) == 0) begin
					k = $urandom_range(1, 40);
					y -= k;
					h += k;
				end
			end
			send_item(pick >= full_pct, x, y, w, h);
			if ($urandom_range(99) == 0) drain();
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 16);
				if (gappy) pause($urandom_range(1, 8));
			end
		end
	endtask

	initial begin
		tracker = new();
		n_settings = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = 1'b0;
		rect_x = '0;
		rect_y = '0;
		rect_width = '0;
		rect_height = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset register values first
		send_item(1'b0, -2048, 2047, -1, 0);
		send_item(1'b1, 0, 0, UI_W, UI_H);
		send_item(1'b1, 0, 0, UI_W, UI_H);
		send_item(1'b1, 10, 10, 0, 5);
		send_item(1'b1, 10, 10, 5, 0);
		send_item(1'b1, 0, 0, -2048, 2047);
		send_item(1'b1, 2047, 2047, 2047, 2047);
		send_item(1'b1, -2048, -2048, 2047, 2047);
		send_item(1'b1, -5, -3, 20, 20);
		send_item(1'b1, UI_W - 1, UI_H - 1, 1, 1);
		send_item(1'b1, 100, 3, 10, 10);
		send_item(1'b1, 0, 793, UI_W, 7);
		configure(8'd1, 4'd15, 2'd0);
		send_item(1'b1, 40, 40, 8, 8);
		send_item(1'b1, 40, 40, 8, 8);
		send_item(1'b1, 40, 41, 8, 8);
		// no area budget at all
		configure(8'd200, 4'd0, 2'd1);
		send_item(1'b1, 1, 1, 1, 1);
		configure(8'd1, 4'd1, 2'd3);
		send_item(1'b1, 7, 9, 30, 30);
		send_item(1'b1, 7, 9, 30, 30);
		send_item(1'b1, 7, 9, 30, 30);
		// limit check off, big areas pass
		configure(8'd0, 4'd0, 2'd2);
		send_item(1'b1, 0, 0, UI_W, UI_H);
		send_item(1'b1, 0, 0, UI_W, UI_H);

		run_phase(8'd10, 4'd2, 2'd0, 8, 10, 10, 1'b1);
		run_phase(8'd255, 4'd15, 2'd2, 8, 5, 10, 1'b0);
		run_phase(8'd3, 4'd1, 2'd1, 8, 10, 10, 1'b1);
		// only in-screen partials here so the partial count runs into saturation
		run_phase(8'd0, 4'd7, 2'd0, 512, 0, 0, 1'b1);
		run_phase(8'd1, 4'd0, 2'd3, 8, 10, 15, 1'b1);
		run_phase(8'd50, 4'd4, 2'd2, 8, 10, 10, 1'b0);
		run_phase(eprp_pkg::RESET_PARTIAL_CAP, eprp_pkg::RESET_AREA_CAP,
			eprp_pkg::RESET_ENERGY_LEVEL, 8, 10, 10, 1'b1);

		drain();
		repeat (10) @(posedge clk);
		$display("requests: %0d partial, %0d full (%0d promoted), %0d rejected",
			tracker.n_partial, tracker.n_full, tracker.n_promoted, tracker.n_reject);
		$display("register settings: %0d, highest partial count seen: %0d",
			n_settings, tracker.peak_count);
		if (tracker.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/eprp_pkg.sv
hdl/eprp_plan.sv
hdl/epaper_partial_refresh_planner_core.sv
dv/tb_epaper_partial_refresh_planner_core.sv
